>>> design/swpf_pkg.sv
// Shared types and constants of the whitelist packet filter.
// Used by swpf_ctrl, swpf_dp and stateless_whitelist_packet_filter.
package swpf_pkg;

  localparam int unsigned InDataW  = 168;
  localparam int unsigned OutDataW = 16;

  localparam logic [1:0] FAM_V4_OK    = 2'd0;
  localparam logic [1:0] FAM_V4_BAD   = 2'd1;
  localparam logic [1:0] FAM_V6_LOOP  = 2'd2;
  localparam logic [1:0] FAM_V6_OTHER = 2'd3;

  localparam logic [1:0] DIR_IN  = 2'd1;
  localparam logic [1:0] DIR_OUT = 2'd2;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [7:0]  LOOP_NET  = 8'd127;
  localparam int unsigned NET_SHIFT = 24;

  typedef enum logic [1:0] {
    CMD_CLASSIFY = 2'd0,
    CMD_ADD      = 2'd1,
    CMD_DELETE   = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_NOT_FOUND = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [1:0]  family;
    logic [1:0]  direction;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [7:0]  protocol;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [1:0]  tcp_flags;
    logic [31:0] rule_ip;
    logic [15:0] rule_port;
    logic [7:0]  rule_proto;
  } item_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] port;
    logic [7:0]  proto;
    logic [1:0]  dir;
  } rule_t;

  // controller to datapath
  typedef struct packed {
    logic    latch;
    logic    add_wr;
    logic    clear;
    logic    scan_start;
    logic    scan_step;
    logic    shift_start;
    logic    shift_step;
    logic    dec;
    logic    res_set;
    logic    res_verdict;
    status_e res_status;
    logic    out_load;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic cls_fast;
    logic cls_fast_verdict;
    logic full;
    logic hit;
    logic scan_end;
    logic shift_end;
  } sts_t;

endpackage

>>> design/swpf_dp.sv
// Datapath of the whitelist packet filter: item register, rule memory,
// scan and compaction pointers, rule compare and result registers.
// Depends on swpf_pkg.
module swpf_dp #(
  parameter int unsigned MAX_RULES = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_wr_en_i,
  input  logic             cfg_wr_data_i,
  input  swpf_pkg::item_t  item_i,
  input  swpf_pkg::ctl_t   ctl_i,
  output swpf_pkg::sts_t   sts_o,
  output logic             out_verdict_o,
  output logic [1:0]       out_status_o,
  output logic [6:0]       out_rules_o
);
  import swpf_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_RULES + 1);
  localparam int unsigned IdxW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

  item_t            item_q;
  logic             iso_q;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  ptr_q, ptr_d;
  logic             rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]  rd_idx_q;
  rule_t            rdata_q;
  rule_t            mem_q [MAX_RULES];
  logic             res_verdict_q;
  status_e          res_status_q;
  logic             issue;
  logic             wr_en;
  logic [IdxW-1:0]  wr_addr;
  rule_t            wr_data;
  rule_t            item_rule;
  logic [1:0]       pdir;
  logic [31:0]      rem_ip;
  logic [15:0]      rem_port;
  logic             loopback;
  logic             tcp_pass;
  logic             match;
  logic             cls_fast;
  logic             cls_fast_verdict;
  logic [CntW+6:0]  count_ext;

  assign item_rule = '{ip: item_q.rule_ip, port: item_q.rule_port,
                       proto: item_q.rule_proto, dir: item_q.direction};

  // packet view used by the rule compare
  always_comb begin
    pdir     = (item_q.direction == DIR_IN) ? DIR_IN : DIR_OUT;
    rem_ip   = (pdir == DIR_IN) ? item_q.src_ip : item_q.dst_ip;
    if (item_q.protocol == PROTO_TCP) begin
      rem_port = item_q.dst_port;
    end else if (item_q.protocol == PROTO_UDP) begin
      rem_port = (pdir == DIR_IN) ? item_q.src_port : item_q.dst_port;
    end else begin
      rem_port = 16'd0;
    end
    loopback = (item_q.src_ip[31:NET_SHIFT] == LOOP_NET) ||
               (item_q.dst_ip[31:NET_SHIFT] == LOOP_NET);
    tcp_pass = (item_q.protocol == PROTO_TCP) &&
               !(item_q.tcp_flags[0] && !item_q.tcp_flags[1]);
  end

  // verdicts that need no table walk
  always_comb begin
    cls_fast         = 1'b1;
    cls_fast_verdict = 1'b0;
    if (!iso_q) begin
      cls_fast_verdict = 1'b1;
    end else if (item_q.family == FAM_V6_LOOP) begin
      cls_fast_verdict = 1'b1;
    end else if (item_q.family == FAM_V6_OTHER) begin
      cls_fast_verdict = 1'b0;
    end else if (loopback) begin
      cls_fast_verdict = 1'b1;
    end else if (item_q.family == FAM_V4_BAD) begin
      cls_fast_verdict = 1'b0;
    end else if (tcp_pass) begin
      cls_fast_verdict = 1'b1;
    end else if (count_q == '0) begin
      cls_fast_verdict = 1'b0;
    end else begin
      cls_fast = 1'b0;
    end
  end

  // compare the entry read last cycle
  always_comb begin
    if (item_q.cmd == CMD_DELETE) begin
      match = (rdata_q == item_rule);
    end else begin
      match = ((rdata_q.ip == '0) || (rdata_q.ip == rem_ip)) &&
              ((rdata_q.port == '0) || (rdata_q.port == rem_port)) &&
              ((rdata_q.proto == '0) || (rdata_q.proto == item_q.protocol)) &&
              ((rdata_q.dir == '0) || (rdata_q.dir == pdir));
    end
  end

  assign sts_o.cmd              = item_q.cmd;
  assign sts_o.cls_fast         = cls_fast;
  assign sts_o.cls_fast_verdict = cls_fast_verdict;
  assign sts_o.full             = (count_q == CntW'(MAX_RULES));
  assign sts_o.hit              = rd_vld_q && match;
  assign sts_o.scan_end         = !sts_o.hit && (ptr_q == count_q);
  assign sts_o.shift_end        = !rd_vld_q && (ptr_q == count_q);

  assign issue = (ctl_i.scan_step || ctl_i.shift_step) && (ptr_q < count_q);

  // write an added rule at the table end, or move an entry to the previous slot during compaction
  assign wr_en   = ctl_i.add_wr || (ctl_i.shift_step && rd_vld_q);
  assign wr_addr = ctl_i.add_wr ? count_q[IdxW-1:0] : rd_idx_q - IdxW'(1);
  assign wr_data = ctl_i.add_wr ? item_rule : rdata_q;

  always_comb begin
    count_d = count_q;
    if (ctl_i.clear) begin
      count_d = '0;
    end else if (ctl_i.add_wr) begin
      count_d = count_q + CntW'(1);
    end else if (ctl_i.dec) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    ptr_d    = ptr_q;
    rd_vld_d = rd_vld_q;
    if (ctl_i.scan_start) begin
      ptr_d    = '0;
      rd_vld_d = 1'b0;
    end else if (ctl_i.shift_start) begin
      ptr_d    = CntW'(rd_idx_q) + CntW'(1);
      rd_vld_d = 1'b0;
    end else if (ctl_i.scan_step || ctl_i.shift_step) begin
      rd_vld_d = issue;
      if (issue) begin
        ptr_d = ptr_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iso_q    <= 1'b0;
      count_q  <= '0;
      ptr_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        iso_q <= cfg_wr_data_i;
      end
      count_q  <= count_d;
      ptr_q    <= ptr_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (issue) begin
      rdata_q  <= mem_q[ptr_q[IdxW-1:0]];
      rd_idx_q <= ptr_q[IdxW-1:0];
    end
  end

  assign count_ext = {7'd0, count_q};

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      item_q <= item_i;
    end
    if (ctl_i.res_set) begin
      res_verdict_q <= ctl_i.res_verdict;
      res_status_q  <= ctl_i.res_status;
    end
    if (ctl_i.out_load) begin
      out_verdict_o <= res_verdict_q;
      out_status_o  <= res_status_q;
      out_rules_o   <= count_ext[6:0];
    end
  end

endmodule

>>> design/swpf_ctrl.sv
// Controller of the whitelist packet filter: sequences one command
// through execute, table scan, compaction and result hand-off.
// Depends on swpf_pkg.
module swpf_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  swpf_pkg::sts_t  sts_i,
  output swpf_pkg::ctl_t  ctl_o
);
  import swpf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;
  logic   out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_free    = !out_vld_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts_i.cmd)
          CMD_CLASSIFY: begin
            if (sts_i.cls_fast) begin
              ctl_o.res_set     = 1'b1;
              ctl_o.res_verdict = sts_i.cls_fast_verdict;
              ctl_o.res_status  = STS_OK;
              state_d           = S_DONE;
            end else begin
              ctl_o.scan_start = 1'b1;
              state_d          = S_SCAN;
            end
          end
          CMD_ADD: begin
            ctl_o.res_set    = 1'b1;
            ctl_o.res_status = sts_i.full ? STS_FULL : STS_OK;
            ctl_o.add_wr     = !sts_i.full;
            state_d          = S_DONE;
          end
          CMD_DELETE: begin
            ctl_o.scan_start = 1'b1;
            state_d          = S_SCAN;
          end
          default: begin
            ctl_o.clear      = 1'b1;
            ctl_o.res_set    = 1'b1;
            ctl_o.res_status = STS_OK;
            state_d          = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        if (sts_i.hit && (sts_i.cmd == CMD_DELETE)) begin
          ctl_o.shift_start = 1'b1;
          state_d           = S_SHIFT;
        end else if (sts_i.hit) begin
          ctl_o.res_set     = 1'b1;
          ctl_o.res_verdict = 1'b1;
          ctl_o.res_status  = STS_OK;
          state_d           = S_DONE;
        end else if (sts_i.scan_end) begin
          ctl_o.res_set    = 1'b1;
          ctl_o.res_status = (sts_i.cmd == CMD_DELETE) ? STS_NOT_FOUND : STS_OK;
          state_d          = S_DONE;
        end else begin
          ctl_o.scan_step = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sts_i.shift_end) begin
          ctl_o.dec        = 1'b1;
          ctl_o.res_set    = 1'b1;
          ctl_o.res_status = STS_OK;
          state_d          = S_DONE;
        end else begin
          ctl_o.shift_step = 1'b1;
        end
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (out_free) begin
          ctl_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (ctl_o.out_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

>>> design/stateless_whitelist_packet_filter.sv
// Whitelist packet filter, one command per word: classify, add, delete, clear.
// Add, clear and classify verdicts that need no rule walk go straight from execute
// to result; other classifies and deletes walk the table, one memory read a cycle
// over the N rules, and a delete that finds its rule then compacts the table.
// One command is in flight at a time: a new word is taken only while idle.
// Reset clears the rule count and the mode register; the rule memory is not cleared.
module stateless_whitelist_packet_filter #(
  parameter int unsigned MAX_RULES = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_wr_en_i,
  input  logic                             cfg_wr_data_i,   // isolated_mode
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // family, direction, src_ip, dst_ip, protocol, src_port, dst_port,
  // tcp_flags, rule_ip, rule_port, rule_proto, zero pad
  input  logic [swpf_pkg::InDataW-1:0]     s_axis_tdata,
  input  logic [1:0]                       s_axis_tuser,    // cmd
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // verdict, status, rules_in_use, zero pad
  output logic [swpf_pkg::OutDataW-1:0]    m_axis_tdata
);
  import swpf_pkg::*;

  item_t      item;
  ctl_t       ctl;
  sts_t       sts;
  logic       out_verdict;
  logic [1:0] out_status;
  logic [6:0] out_rules;

  always_comb begin
    item.cmd        = cmd_e'(s_axis_tuser);
    item.family     = s_axis_tdata[1:0];
    item.direction  = s_axis_tdata[3:2];
    item.src_ip     = s_axis_tdata[35:4];
    item.dst_ip     = s_axis_tdata[67:36];
    item.protocol   = s_axis_tdata[75:68];
    item.src_port   = s_axis_tdata[91:76];
    item.dst_port   = s_axis_tdata[107:92];
    item.tcp_flags  = s_axis_tdata[109:108];
    item.rule_ip    = s_axis_tdata[141:110];
    item.rule_port  = s_axis_tdata[157:142];
    item.rule_proto = s_axis_tdata[165:158];
  end

  swpf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  swpf_dp #(
    .MAX_RULES (MAX_RULES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .item_i        (item),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .out_verdict_o (out_verdict),
    .out_status_o  (out_status),
    .out_rules_o   (out_rules)
  );

  assign m_axis_tdata = {6'd0, out_rules, out_status, out_verdict};

endmodule

>>> bench/swpf_verdict_checker.sv
`timescale 1ns / 1ps
// Result checker for the whitelist packet filter: keeps its own rule table and
// mode bit, predicts one result word per accepted command and compares it.
// Depends on swpf_pkg for the command word layout and the code values.
module swpf_verdict_checker #(
  parameter int unsigned MAX_RULES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_wr_en_i,
  input  logic                          cfg_wr_data_i,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [swpf_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic [1:0]                    s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [swpf_pkg::OutDataW-1:0] m_axis_tdata,
  output int                            fail_count_o,
  output int                            outstanding_o
);
  import swpf_pkg::*;

  localparam int SYN_BIT = 0;
  localparam int ACK_BIT = 1;

  typedef struct packed {
    logic       verdict;
    logic [1:0] status;
    logic [6:0] rules_in_use;
  } outcome_t;

  rule_t    rules [MAX_RULES];
  int       rule_cnt;
  logic     isolated;
  outcome_t pending_outcomes [$];
  int       fails = 0;
  item_t    word_in;
  logic [1:0] pad_bits;
  outcome_t got, want;

  function automatic logic rule_hits(rule_t e, logic [31:0] ip, logic [15:0] port,
                                     logic [7:0] proto, logic [1:0] dir);
    return (e.ip == '0 || e.ip == ip) && (e.port == '0 || e.port == port) &&
           (e.proto == '0 || e.proto == proto) && (e.dir == '0 || e.dir == dir);
  endfunction

  function automatic logic filter_verdict(item_t w);
    logic [1:0]  dir;
    logic [31:0] remote;
    logic [15:0] svc;
    if (!isolated) return 1'b1;
    if (w.family == FAM_V6_LOOP) return 1'b1;
    if (w.family == FAM_V6_OTHER) return 1'b0;
    if ((w.src_ip >> NET_SHIFT) == LOOP_NET || (w.dst_ip >> NET_SHIFT) == LOOP_NET)
      return 1'b1;
    if (w.family == FAM_V4_BAD) return 1'b0;
    // of TCP, only a pure SYN has to find a rule
    if (w.protocol == PROTO_TCP && !(w.tcp_flags[SYN_BIT] && !w.tcp_flags[ACK_BIT]))
      return 1'b1;
    dir = (w.direction == DIR_IN) ? DIR_IN : DIR_OUT;
    remote = (dir == DIR_IN) ? w.src_ip : w.dst_ip;
    if (w.protocol == PROTO_TCP) svc = w.dst_port;
    else if (w.protocol == PROTO_UDP) svc = (dir == DIR_IN) ? w.src_port : w.dst_port;
    else svc = '0;
    for (int i = 0; i < rule_cnt; i++)
      if (rule_hits(rules[i], remote, svc, w.protocol, dir)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic outcome_t apply_command(item_t w);
    outcome_t o;
    rule_t    r;
    int       hit;
    o = '0;
    r.ip = w.rule_ip;
    r.port = w.rule_port;
    r.proto = w.rule_proto;
    r.dir = w.direction;
    case (w.cmd)
      CMD_CLASSIFY: o.verdict = filter_verdict(w);
      CMD_ADD: begin
        if (rule_cnt >= MAX_RULES) begin
          o.status = STS_FULL;
        end else begin
          rules[rule_cnt] = r;
          rule_cnt++;
        end
      end
      CMD_DELETE: begin
        hit = -1;
        for (int i = 0; i < rule_cnt && hit < 0; i++)
          if (rules[i] == r) hit = i;
        if (hit < 0) begin
          o.status = STS_NOT_FOUND;
        end else begin
          // close the gap left by the removed rule
          for (int i = hit; i + 1 < rule_cnt; i++) rules[i] = rules[i + 1];
          rule_cnt--;
        end
      end
      default: rule_cnt = 0;
    endcase
    o.rules_in_use = 7'(rule_cnt);
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_outcomes.delete();
      rule_cnt = 0;
      isolated = 1'b0;
      outstanding_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.verdict = m_axis_tdata[0];
        got.status = m_axis_tdata[2:1];
        got.rules_in_use = m_axis_tdata[9:3];
        if (pending_outcomes.size() == 0) begin
          $error("result word with no command pending: %h", m_axis_tdata);
          fails++;
        end else begin
          want = pending_outcomes.pop_front();
          if (got.verdict !== want.verdict) begin
            $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
            fails++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fails++;
          end
          if (got.rules_in_use !== want.rules_in_use) begin
            $error("rules_in_use: expected %0d, got %0d", want.rules_in_use,
                   got.rules_in_use);
            fails++;
          end
        end
      end
      if (cfg_wr_en_i) isolated = cfg_wr_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        {pad_bits, word_in.rule_proto, word_in.rule_port, word_in.rule_ip,
         word_in.tcp_flags, word_in.dst_port, word_in.src_port, word_in.protocol,
         word_in.dst_ip, word_in.src_ip, word_in.direction, word_in.family} = s_axis_tdata;
        word_in.cmd = cmd_e'(s_axis_tuser);
        pending_outcomes.push_back(apply_command(word_in));
      end
      outstanding_o <= pending_outcomes.size();
      fail_count_o <= fails;
    end
  end

endmodule

>>> bench/tb_stateless_whitelist_packet_filter.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the whitelist packet filter: directed commands, then
// random phases under both modes with bursty input and a stalling output side.
// Depends on swpf_pkg, the filter RTL and swpf_verdict_checker.
module tb_stateless_whitelist_packet_filter;
  import swpf_pkg::*;

  localparam int unsigned MAX_RULES     = 64;
  localparam int          RANDOM_PHASES = 7;
  localparam int          PHASE_WORDS   = 100;
  localparam int          FILL_ADDS     = 68;
  localparam int          LONG_HOLD     = 400;
  localparam int          DRAIN_CYCLES  = 200;

  localparam logic [1:0]  DIR_ANY       = 2'd0;
  localparam logic [1:0]  DIR_BAD       = 2'd3;
  localparam logic [1:0]  FLAG_SYN      = 2'b01;
  localparam logic [1:0]  FLAG_ACK      = 2'b10;
  localparam logic [7:0]  PROTO_ICMP    = 8'd1;
  localparam logic        MODE_NORMAL   = 1'b0;
  localparam logic        MODE_ISOLATED = 1'b1;

  localparam logic [31:0] HOST_A = 32'h0A00_0005;
  localparam logic [31:0] HOST_B = 32'hC0A8_0001;
  localparam logic [31:0] HOST_C = 32'h0808_0808;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_wr_en_i;
  logic                cfg_wr_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  int                  fail_count;
  int                  outstanding;

  bit          hold_req = 1'b0;
  int          burst_left;
  logic [31:0] host_pool [8];
  logic [15:0] svc_pool [8];
  rule_t       rule_book [$];

  stateless_whitelist_packet_filter #(.MAX_RULES(MAX_RULES)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  swpf_verdict_checker #(.MAX_RULES(MAX_RULES)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("stateless_whitelist_packet_filter test failed");
    $finish;
  end

  // Output side: random stall patterns, plus one long hold-off on request.
  initial begin : sink_pacing
    int stall_left;
    int stall_kind;
    stall_left = 0;
    stall_kind = 0;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        if (stall_left == 0) begin
          stall_kind = $urandom_range(0, 3);
          stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        case (stall_kind)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= ($urandom_range(0, 4) == 0);
          default: m_axis_tready <= !m_axis_tready;
        endcase
      end
    end
  end

  function automatic item_t noise_word();
    logic [191:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return bits[InDataW-1:0];
  endfunction

  function automatic item_t packet(logic [1:0] fam, logic [1:0] dir, logic [31:0] sip,
                                   logic [31:0] dip, logic [7:0] proto,
                                   logic [15:0] sport, logic [15:0] dport,
                                   logic [1:0] flags);
    item_t it;
    it = '0;
    it.cmd = CMD_CLASSIFY;
    it.family = fam;
    it.direction = dir;
    it.src_ip = sip;
    it.dst_ip = dip;
    it.protocol = proto;
    it.src_port = sport;
    it.dst_port = dport;
    it.tcp_flags = flags;
    return it;
  endfunction

  function automatic item_t rule_word(cmd_e c, logic [31:0] ip, logic [15:0] port,
                                      logic [7:0] proto, logic [1:0] dir);
    item_t it;
    it = '0;
    it.cmd = c;
    it.rule_ip = ip;
    it.rule_port = port;
    it.rule_proto = proto;
    it.direction = dir;
    return it;
  endfunction

  function automatic logic [31:0] pick_ip();
    case ($urandom_range(0, 9))
      0:          return '0;
      1:          return '1;
      2:          return {LOOP_NET, 24'($urandom)};
      3, 4, 5, 6: return host_pool[$urandom_range(0, 7)];
      default:    return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_port();
    case ($urandom_range(0, 9))
      0:             return '0;
      1:             return '1;
      2, 3, 4, 5, 6: return svc_pool[$urandom_range(0, 7)];
      default:       return 16'($urandom);
    endcase
  endfunction

  function automatic item_t random_packet();
    item_t it;
    it = noise_word();
    it.cmd = CMD_CLASSIFY;
    case ($urandom_range(0, 9))
      7:       it.family = FAM_V4_BAD;
      8:       it.family = FAM_V6_LOOP;
      9:       it.family = FAM_V6_OTHER;
      default: it.family = FAM_V4_OK;
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3: it.direction = DIR_IN;
      4, 5, 6, 7: it.direction = DIR_OUT;
      8:          it.direction = DIR_ANY;
      default:    it.direction = DIR_BAD;
    endcase
    it.src_ip = pick_ip();
    it.dst_ip = pick_ip();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: it.protocol = PROTO_TCP;
      4, 5, 6:    it.protocol = PROTO_UDP;
      7:          it.protocol = PROTO_ICMP;
      8:          it.protocol = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default:    it.protocol = 8'($urandom);
    endcase
    it.src_port = pick_port();
    it.dst_port = pick_port();
    it.tcp_flags = $urandom_range(0, 1) ? FLAG_SYN : 2'($urandom);
    return it;
  endfunction

  function automatic item_t random_rule_word(cmd_e c);
    item_t it;
    int    k;
    it = noise_word();
    it.cmd = c;
    if (c == CMD_DELETE && rule_book.size() != 0 && $urandom_range(0, 3) != 0) begin
      k = $urandom_range(0, rule_book.size() - 1);
      it.rule_ip = rule_book[k].ip;
      it.rule_port = rule_book[k].port;
      it.rule_proto = rule_book[k].proto;
      it.direction = rule_book[k].dir;
    end else begin
      case ($urandom_range(0, 5))
        0, 1:    it.rule_ip = '0;
        2:       it.rule_ip = $urandom;
        default: it.rule_ip = host_pool[$urandom_range(0, 7)];
      endcase
      case ($urandom_range(0, 5))
        0, 1:    it.rule_port = '0;
        2:       it.rule_port = 16'($urandom);
        default: it.rule_port = svc_pool[$urandom_range(0, 7)];
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2: it.rule_proto = '0;
        3, 4:    it.rule_proto = PROTO_TCP;
        5, 6:    it.rule_proto = PROTO_UDP;
        7:       it.rule_proto = 8'($urandom);
        8:       it.rule_proto = PROTO_ICMP;
        default: it.rule_proto = 8'hFF;
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2: it.direction = DIR_ANY;
        3, 4, 5: it.direction = DIR_IN;
        6, 7, 8: it.direction = DIR_OUT;
        default: it.direction = DIR_BAD;
      endcase
    end
    return it;
  endfunction

  function automatic item_t mixed_word();
    item_t it;
    int    r;
    r = $urandom_range(0, 99);
    if (r < 56) return random_packet();
    if (r < 78) return random_rule_word(CMD_ADD);
    if (r < 98) return random_rule_word(CMD_DELETE);
    it = noise_word();
    it.cmd = CMD_CLEAR;
    return it;
  endfunction

  // Drive one word and hold it until the filter takes it; bursts and gaps
  // are decided here.
  task automatic send_word(input item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, it.rule_proto, it.rule_port, it.rule_ip, it.tcp_flags,
                     it.dst_port, it.src_port, it.protocol, it.dst_ip, it.src_ip,
                     it.direction, it.family};
    s_axis_tuser <= it.cmd;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Send a command and keep the list of live rules in step for later deletes.
  task automatic issue(input item_t it);
    rule_t r;
    int    idx;
    r.ip = it.rule_ip;
    r.port = it.rule_port;
    r.proto = it.rule_proto;
    r.dir = it.direction;
    send_word(it);
    case (it.cmd)
      CMD_ADD: if (rule_book.size() < MAX_RULES) rule_book.push_back(r);
      CMD_DELETE: begin
        idx = -1;
        for (int i = 0; i < rule_book.size() && idx < 0; i++)
          if (rule_book[i] == r) idx = i;
        if (idx >= 0) rule_book.delete(idx);
      end
      CMD_CLEAR: rule_book.delete();
      default: ;
    endcase
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic set_mode(input logic isolated);
    cfg_wr_en_i <= 1'b1;
    cfg_wr_data_i <= isolated;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
  endtask

  initial begin : stimulus
    item_t all_ones;
    int    words;
    rst_ni <= 1'b0;
    cfg_wr_en_i <= 1'b0;
    cfg_wr_data_i <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= CMD_CLASSIFY;
    burst_left = 0;
    foreach (host_pool[i]) host_pool[i] = $urandom;
    foreach (svc_pool[i]) svc_pool[i] = 16'($urandom_range(1, 65535));
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // normal mode: everything passes, table commands still count
    set_mode(MODE_NORMAL);
    issue(packet(FAM_V6_OTHER, DIR_IN, HOST_C, HOST_B, PROTO_TCP, 16'd1234, 16'd80,
                 FLAG_SYN));
    issue(packet(FAM_V4_BAD, DIR_OUT, HOST_B, HOST_C, PROTO_UDP, 16'd53, 16'd53, '0));
    issue(rule_word(CMD_DELETE, HOST_A, 16'd53, PROTO_UDP, DIR_IN));
    issue(rule_word(CMD_ADD, HOST_A, 16'd53, PROTO_UDP, DIR_IN));
    issue(rule_word(CMD_CLEAR, '0, '0, '0, DIR_ANY));
    drain();

    set_mode(MODE_ISOLATED);
    issue(rule_word(CMD_ADD, HOST_A, 16'd53, PROTO_UDP, DIR_IN));
    issue(rule_word(CMD_ADD, '0, 16'd443, PROTO_TCP, DIR_ANY));
    issue(rule_word(CMD_ADD, HOST_B, '0, '0, DIR_OUT));
    issue(rule_word(CMD_ADD, '0, '0, '0, DIR_BAD));
    issue(packet(FAM_V6_LOOP, DIR_IN, HOST_A, HOST_B, PROTO_UDP, 16'd53, 16'd53, '0));
    issue(packet(FAM_V6_OTHER, DIR_IN, HOST_A, HOST_B, PROTO_UDP, 16'd53, 16'd53, '0));
    issue(packet(FAM_V4_OK, DIR_IN, 32'h7F00_0001, HOST_B, PROTO_UDP, 16'd1000,
                 16'd2000, '0));
    issue(packet(FAM_V4_BAD, DIR_OUT, HOST_B, 32'h7F12_3456, PROTO_UDP, 16'd1000,
                 16'd2000, '0));
    issue(packet(FAM_V4_BAD, DIR_IN, HOST_A, HOST_B, PROTO_UDP, 16'd53, 16'd53, '0));
    issue(packet(FAM_V4_OK, DIR_IN, HOST_C, HOST_B, PROTO_TCP, 16'd1234, 16'd80,
                 FLAG_ACK));
    issue(packet(FAM_V4_OK, DIR_IN, HOST_C, HOST_B, PROTO_TCP, 16'd1234, 16'd80,
                 FLAG_SYN | FLAG_ACK));
    issue(packet(FAM_V4_OK, DIR_IN, HOST_C, HOST_B, PROTO_TCP, 16'd1234, 16'd443,
                 FLAG_SYN));
    issue(packet(FAM_V4_OK, DIR_IN, HOST_C, HOST_B, PROTO_TCP, 16'd1234, 16'd80,
                 FLAG_SYN));
    issue(packet(FAM_V4_OK, DIR_IN, HOST_A, HOST_B, PROTO_UDP, 16'd53, 16'd9999, '0));
    issue(packet(FAM_V4_OK, DIR_OUT, HOST_C, HOST_A, PROTO_UDP, 16'd9999, 16'd53, '0));
    issue(packet(FAM_V4_OK, DIR_ANY, HOST_C, HOST_B, PROTO_UDP, 16'd5000, 16'd6000,
                 '0));
    issue(packet(FAM_V4_OK, DIR_BAD, HOST_C, HOST_B, PROTO_ICMP, 16'd7, 16'd7, '0));
    issue(rule_word(CMD_DELETE, '0, 16'd443, PROTO_TCP, DIR_IN));
    issue(rule_word(CMD_DELETE, HOST_A, 16'd53, PROTO_UDP, DIR_IN));
    issue(packet(FAM_V4_OK, DIR_IN, HOST_A, HOST_B, PROTO_UDP, 16'd53, 16'd9999, '0));
    all_ones = '1;
    all_ones.cmd = CMD_CLASSIFY;
    issue(all_ones);
    issue(packet(FAM_V4_OK, DIR_ANY, '0, '0, '0, '0, '0, '0));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      if (p == 0) set_mode(MODE_ISOLATED);
      else if (p == 1) set_mode(MODE_NORMAL);
      else set_mode($urandom_range(0, 3) != 0);
      // back-pressure the output while input keeps coming
      if (p == 2) hold_req = 1'b1;
      words = PHASE_WORDS;
      if (p == 3) begin
        // fill the table past its end, then run mixed commands from a full table
        issue(rule_word(CMD_CLEAR, '0, '0, '0, DIR_ANY));
        repeat (FILL_ADDS) issue(random_rule_word(CMD_ADD));
        words = PHASE_WORDS - FILL_ADDS - 1;
      end
      repeat (words) issue(mixed_word());
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (outstanding != 0) $error("%0d result words never arrived", outstanding);
    if (fail_count == 0 && outstanding == 0)
      $display("stateless_whitelist_packet_filter test passed");
    else
      $display("stateless_whitelist_packet_filter test failed");
    $finish;
  end

endmodule
